// ===== rtl/core/ppm_pulse_frame_decoder_unit_macros.svh =====
// assertion macros used by the ppm pulse frame decoder controller
// expects clk and rst_n in the scope of the including module
`ifndef PPM_PULSE_FRAME_DECODER_UNIT_MACROS_SVH
`define PPM_PULSE_FRAME_DECODER_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define PPFD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PPFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/ppfd_pkg.sv =====
// shared constants, register codes and controller/datapath interface types
// used by the ppm pulse frame decoder controller, datapath and top level
`timescale 1ns / 1ps

package ppfd_pkg;

    localparam int unsigned NUM_CHANNELS  = 8;
    localparam int unsigned NUM_SETPOINTS = 4;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned PCT_W    = 14;
    localparam int unsigned PROD_W   = TICK_W + PCT_W;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned ITER_W   = 4;
    localparam int unsigned TENTH_W  = 11;
    localparam int unsigned SP_W     = 12;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [PCT_W-1:0]  FULL_SCALE = 14'd10000;
    // 52429 / 2^19 is an exact reciprocal of ten for 16 bit operands
    localparam logic [TICK_W-1:0] RECIP_TEN  = 16'd52429;
    localparam int unsigned       RECIP_SHIFT = 19;
    localparam logic signed [SP_W-1:0] THR_BASE = 12'sd1000;
    localparam logic signed [SP_W-1:0] RPY_BASE = -12'sd500;

    localparam logic [TICK_W-1:0] SYNC_RESET = 16'd500;
    localparam logic [TICK_W-1:0] MIN_RESET  = 16'd60;
    localparam logic [TICK_W-1:0] MAX_RESET  = 16'd160;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MAX      = 2'd2;

    localparam logic OP_PULSE    = 1'b0;
    localparam logic OP_OVERFLOW = 1'b1;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        logic             div_step;
        logic             scale_en;
        logic             out_load;
        logic             active;
        logic             fsync;
        logic             serr;
        logic             wrote;
        logic [IDX_W-1:0] idx;
    } ppfd_cmd_t;

    typedef struct packed {
        logic is_sync;
    } ppfd_sts_t;

endpackage

// ===== rtl/core/ppfd_ctrl.sv =====
// controller: frame mode, channel counter and sequencing of the datapath
// depends on ppfd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ppm_pulse_frame_decoder_unit_macros.svh"

module ppfd_ctrl
    import ppfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      in_op,
    output logic      out_valid,
    input  logic      out_ready,
    input  ppfd_sts_t sts,
    output ppfd_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              fsync_reg, fsync_next;
    logic              serr_reg, serr_next;
    logic              wrote_reg, wrote_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              oval_reg, oval_next;
    logic              accept;
    logic              out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !oval_reg || out_ready;
    assign out_valid = oval_reg;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        iter_next  = iter_reg;
        fsync_next = fsync_reg;
        serr_next  = serr_reg;
        wrote_next = wrote_reg;
        idx_next   = idx_reg;
        oval_next  = oval_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fsync_next = 1'b0;
                    serr_next  = 1'b0;
                    wrote_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_FIN;
                    if (in_op == OP_OVERFLOW)
                    begin
                        mode_next = 1'b0;
                        cnt_next  = '0;
                        serr_next = 1'b1;
                    end
                    else if (sts.is_sync)
                    begin
                        // frame boundary, either mode
                        mode_next  = 1'b1;
                        cnt_next   = '0;
                        fsync_next = 1'b1;
                    end
                    else if (!mode_reg)
                    begin
                        // short pulse while waiting is dropped
                    end
                    else if (cnt_reg >= CNT_W'(NUM_CHANNELS))
                    begin
                        mode_next = 1'b0;
                        cnt_next  = '0;
                        serr_next = 1'b1;
                    end
                    else
                    begin
                        wrote_next = 1'b1;
                        idx_next   = cnt_reg[IDX_W-1:0];
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                iter_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(PCT_W - 1))
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load     = accept;
        cmd.mul_en   = (state_reg == S_MUL);
        cmd.div_step = (state_reg == S_DIV);
        cmd.scale_en = (state_reg == S_SCALE);
        cmd.out_load = (state_reg == S_FIN) && out_free;
        cmd.active   = mode_reg;
        cmd.fsync    = fsync_reg;
        cmd.serr     = serr_reg;
        cmd.wrote    = wrote_reg;
        cmd.idx      = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= 1'b0;
            cnt_reg   <= '0;
            iter_reg  <= '0;
            fsync_reg <= 1'b0;
            serr_reg  <= 1'b0;
            wrote_reg <= 1'b0;
            idx_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            iter_reg  <= iter_next;
            fsync_reg <= fsync_next;
            serr_reg  <= serr_next;
            wrote_reg <= wrote_next;
            idx_reg   <= idx_next;
            oval_reg  <= oval_next;
        end
    end

    `PPFD_ASSERT_IMPLY(a_wait_cnt_zero, !mode_reg, cnt_reg == '0, "counter not zero while waiting")
    `PPFD_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(NUM_CHANNELS), "channel counter overrun")
    `PPFD_ASSERT_IMPLY(a_wrote_active, (state_reg == S_FIN) && wrote_reg, mode_reg && !fsync_reg && !serr_reg, "channel result with bad flags")
    `PPFD_ASSERT_IMPLY(a_div_iter, state_reg == S_DIV, iter_reg < ITER_W'(PCT_W), "divider step count overrun")

endmodule

// ===== rtl/core/ppfd_dpath.sv =====
// datapath: config registers, clamp, scale multiply, restoring divider,
// setpoint mapping and the result register; depends on ppfd_pkg
`timescale 1ns / 1ps

module ppfd_dpath
    import ppfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [TICK_W-1:0]     cfg_wdata,
    input  logic [TICK_W-1:0]     pulse,
    input  ppfd_cmd_t             cmd,
    output ppfd_sts_t             sts,
    output logic                  o_active,
    output logic                  o_fsync,
    output logic                  o_serr,
    output logic                  o_wrote,
    output logic [IDX_W-1:0]      o_idx,
    output logic [PCT_W-1:0]      o_pct,
    output logic                  o_spv,
    output logic signed [SP_W-1:0] o_setpoint
);

    logic [TICK_W-1:0]  thr_reg, lo_reg, hi_reg;
    logic [TICK_W-1:0]  diff_reg, span_reg;
    logic               span_ok_reg;
    logic [TICK_W-1:0]  rem_reg;
    logic [PCT_W-1:0]   quo_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [TENTH_W-1:0] tenth_reg;
    logic [TICK_W-1:0]  w_clamp;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  tenth_prod;
    logic [TICK_W+1:0]  trial;
    logic               trial_ge;
    logic [PCT_W-1:0]   pct_sel;
    logic               spv;
    logic signed [SP_W-1:0] sp_val;

    assign sts.is_sync = (pulse >= thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= SYNC_RESET;
            lo_reg  <= MIN_RESET;
            hi_reg  <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SYNC_THRESHOLD: thr_reg <= cfg_wdata;
                REG_WIDTH_MIN:      lo_reg  <= cfg_wdata;
                REG_WIDTH_MAX:      hi_reg  <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // clamp into [min, max]
    always_comb
    begin
        if (pulse > hi_reg)
        begin
            w_clamp = hi_reg;
        end
        else if (pulse < lo_reg)
        begin
            w_clamp = lo_reg;
        end
        else
        begin
            w_clamp = pulse;
        end
    end

    assign prod       = PROD_W'(diff_reg) * PROD_W'(FULL_SCALE);
    // quotient fits in PCT_W bits, so the top half of the numerator is below the span
    assign trial      = {1'b0, rem_reg, quo_reg[PCT_W-1]} - {2'b00, span_reg};
    assign trial_ge   = !trial[TICK_W+1];
    assign pct_sel    = span_ok_reg ? quo_reg : '0;
    assign tenth_prod = PROD_W'(pct_sel) * PROD_W'(RECIP_TEN);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            diff_reg    <= w_clamp - lo_reg;
            span_reg    <= hi_reg - lo_reg;
            span_ok_reg <= (hi_reg > lo_reg);
        end
        if (cmd.mul_en)
        begin
            rem_reg <= prod[PROD_W-1:PCT_W];
            quo_reg <= prod[PCT_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial[TICK_W-1:0] : {rem_reg[TICK_W-2:0], quo_reg[PCT_W-1]};
            quo_reg <= {quo_reg[PCT_W-2:0], trial_ge};
        end
        if (cmd.scale_en)
        begin
            pct_reg   <= pct_sel;
            tenth_reg <= tenth_prod[RECIP_SHIFT+TENTH_W-1:RECIP_SHIFT];
        end
    end

    assign spv = cmd.wrote && (cmd.idx < IDX_W'(NUM_SETPOINTS));

    always_comb
    begin
        if (!spv)
        begin
            sp_val = '0;
        end
        else if (cmd.idx == '0)
        begin
            sp_val = $signed({1'b0, tenth_reg}) + THR_BASE;
        end
        else
        begin
            sp_val = $signed({1'b0, tenth_reg}) + RPY_BASE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_active   <= cmd.active;
            o_fsync    <= cmd.fsync;
            o_serr     <= cmd.serr;
            o_wrote    <= cmd.wrote;
            o_idx      <= cmd.idx;
            o_pct      <= cmd.wrote ? pct_reg : '0;
            o_spv      <= spv;
            o_setpoint <= sp_val;
        end
    end

endmodule

// ===== rtl/core/ppm_pulse_frame_decoder_unit.sv =====
// top level of the ppm pulse frame decoder: stream ports, config port,
// controller and datapath; depends on ppfd_pkg, ppfd_ctrl and ppfd_dpath
`timescale 1ns / 1ps

// channel   direction  beat contents
// s_*       in         pulse width (tdata) and op (tuser)
// m_*       out        index, percent, setpoint (tdata) and status flags (tuser)
// cfg_*     in         register index and 16 bit write data
//
// a channel pulse passes from accept to result in order: the clamp, the scale
// multiply, the restoring divider (one quotient bit per cycle), the tenth
// multiply and the load of the result register, which waits for a free output
// sync, overflow and ignored pulses go from accept straight to the result load
// reset clears the frame mode, channel counter and handshake state and loads
// the config defaults; a waiting result holds m_tdata while a new beat is taken

module ppm_pulse_frame_decoder_unit
    import ppfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] pulse_ticks
    input  logic                 s_tuser,   // [0] op
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [3:0] channel_index, [17:4] percent,
                                            // [29:18] setpoint, [31:30] zero
    output logic [4:0]           m_tuser,   // [0] active, [1] frame_sync,
                                            // [2] sync_error, [3] channel_written,
                                            // [4] setpoint_valid
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    ppfd_cmd_t              cmd;
    ppfd_sts_t              sts;
    logic                   o_active;
    logic                   o_fsync;
    logic                   o_serr;
    logic                   o_wrote;
    logic [IDX_W-1:0]       o_idx;
    logic [PCT_W-1:0]       o_pct;
    logic                   o_spv;
    logic signed [SP_W-1:0] o_setpoint;

    // config writes are accepted at any time and registered straight into the config registers
    assign cfg_ready = 1'b1;

    ppfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppfd_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .pulse      (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .o_active   (o_active),
        .o_fsync    (o_fsync),
        .o_serr     (o_serr),
        .o_wrote    (o_wrote),
        .o_idx      (o_idx),
        .o_pct      (o_pct),
        .o_spv      (o_spv),
        .o_setpoint (o_setpoint)
    );

    // pack result beat
    assign m_tdata = {2'b00, o_setpoint, o_pct, o_idx};
    assign m_tuser = {o_spv, o_wrote, o_serr, o_fsync, o_active};

endmodule
